FILE: design/apt3_pkg.sv
// ----------------------------------------------------------------------------
// apt3_pkg
// Shared types and constants for the 3D affine point transform: fixed point
// widths, transform form codes, register indexes and pipeline payloads.
// ----------------------------------------------------------------------------
package apt3_pkg;

   // fixed point widths
   localparam int unsigned AXES        = 3;
   localparam int unsigned COORD_W     = 32;  // Q16.16
   localparam int unsigned COEFF_W     = 21;  // Q5.16
   localparam int unsigned FRAC_W      = 16;
   localparam int unsigned PROD_W      = COORD_W + COEFF_W;   // exact Q21.32
   localparam int unsigned ACC_W       = 56;                  // sum of three products and offset
   localparam int unsigned ROUND_W     = ACC_W - FRAC_W;      // rounded Q.16 before clamp
   localparam int unsigned ROW_W       = AXES * COEFF_W;
   localparam int unsigned CSR_INDEX_W = 3;
   localparam int unsigned CSR_DATA_W  = 64;

   typedef logic signed [COORD_W-1:0] coord_type;
   typedef logic signed [COEFF_W-1:0] coeff_type;
   typedef logic signed [PROD_W-1:0]  prod_type;
   typedef logic signed [ACC_W-1:0]   acc_type;
   typedef logic signed [ROUND_W-1:0] round_type;

   // 1.0 in Q5.16
   localparam coeff_type COEFF_ONE = 21'sd65536;
   // one half LSB of the Q.16 result, placed below the offset
   localparam logic [FRAC_W-1:0] ROUND_HALF = 16'h8000;

   typedef enum logic [1:0] {
      FORM_IDENTITY  = 2'd0,
      FORM_TRANSLATE = 2'd1,
      FORM_SCALE     = 2'd2,
      FORM_AFFINE    = 2'd3
   } form_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_FORM     = 3'd0,
      REG_ROW_X    = 3'd1,
      REG_ROW_Y    = 3'd2,
      REG_ROW_Z    = 3'd3,
      REG_OFFSET_X = 3'd4,
      REG_OFFSET_Y = 3'd5,
      REG_OFFSET_Z = 3'd6
   } reg_index_type;

   // effective transform seen by the datapath: [row][column] coefficients
   typedef struct packed {
      logic [AXES-1:0][AXES-1:0][COEFF_W-1:0] coeff;
      logic [AXES-1:0][COORD_W-1:0]           offset;
   } xform_type;

   // multiplier stage payload
   typedef struct packed {
      logic [AXES-1:0][AXES-1:0][PROD_W-1:0] prod;
      logic [AXES-1:0][ACC_W-1:0]            bias;
   } mul_data_type;

   // partial sum stage payload
   typedef struct packed {
      logic [AXES-1:0][ACC_W-1:0] part_a;
      logic [AXES-1:0][ACC_W-1:0] part_b;
   } part_data_type;

   // rounded stage payload
   typedef struct packed {
      logic [AXES-1:0][ROUND_W-1:0] value;
   } round_data_type;

endpackage

FILE: design/apt3_if.sv
// ----------------------------------------------------------------------------
// apt3 channel interfaces
// Point request, transformed point response and register write channels,
// each a valid/ready channel with source and sink modports.
// ----------------------------------------------------------------------------
interface apt3_req_if;
   import apt3_pkg::*;
   logic      valid;
   logic      ready;
   coord_type point_x;
   coord_type point_y;
   coord_type point_z;
   modport source (output valid, output point_x, output point_y, output point_z,
                   input ready);
   modport sink   (input valid, input point_x, input point_y, input point_z,
                   output ready);
endinterface

interface apt3_rsp_if;
   import apt3_pkg::*;
   logic      valid;
   logic      ready;
   coord_type out_x;
   coord_type out_y;
   coord_type out_z;
   logic      saturated;
   modport source (output valid, output out_x, output out_y, output out_z,
                   output saturated, input ready);
   modport sink   (input valid, input out_x, input out_y, input out_z,
                   input saturated, output ready);
endinterface

interface apt3_csr_if;
   import apt3_pkg::*;
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] reg_index;
   logic [CSR_DATA_W-1:0]  wdata;
   modport source (output valid, output reg_index, output wdata, input ready);
   modport sink   (input valid, input reg_index, input wdata, output ready);
endinterface

FILE: design/affine_point_transform_3d.sv
// ----------------------------------------------------------------------------
// affine_point_transform_3d
// Maps one Q16.16 point per transfer through the configured affine
// transform, with rounding to nearest and saturation to 32 bits.
// ----------------------------------------------------------------------------
// Passes each point through the multiply stage, two add stages and the clamp
// into the response register after the request transfer; the nine 32x21
// multipliers work in parallel, so throughput is one point per cycle as long
// as the response side takes results. Empty pipeline stages fill while the
// response side stalls. Register writes take effect on the next cycle; the
// user must make them while no point is in flight, as the block does not enforce
// it; the write channel is always ready and indexes above six are ignored.
module affine_point_transform_3d (
   input  logic        clock,
   input  logic        reset,
   apt3_req_if.sink    req_chan,
   apt3_rsp_if.source  rsp_chan,
   apt3_csr_if.sink    csr_chan
);
   import apt3_pkg::*;

   xform_type      xform;
   logic           mul_valid, mul_ready;
   mul_data_type   mul_data;
   logic           acc_valid, acc_ready;
   round_data_type acc_data;

   // configuration
   apt3_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .csr_chan (csr_chan),
      .xform    (xform)
   );

   // products
   apt3_mul u_mul (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .xform     (xform),
      .out_valid (mul_valid),
      .out_ready (mul_ready),
      .out_data  (mul_data)
   );

   // sums and rounding
   apt3_acc u_acc (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (mul_valid),
      .in_ready  (mul_ready),
      .in_data   (mul_data),
      .out_valid (acc_valid),
      .out_ready (acc_ready),
      .out_data  (acc_data)
   );

   // clamp and response register
   apt3_sat u_sat (
      .clock    (clock),
      .reset    (reset),
      .in_valid (acc_valid),
      .in_ready (acc_ready),
      .in_data  (acc_data),
      .rsp_chan (rsp_chan)
   );

endmodule

FILE: design/apt3_csr.sv
// ----------------------------------------------------------------------------
// apt3_csr
// Configuration registers and decode of the form into the effective
// coefficient matrix and offsets used by the datapath.
// ----------------------------------------------------------------------------
module apt3_csr (
   input  logic                clock,
   input  logic                reset,
   apt3_csr_if.sink            csr_chan,
   output apt3_pkg::xform_type xform
);
   import apt3_pkg::*;

   form_type                     form_ff, form_in;
   logic [AXES-1:0][ROW_W-1:0]   row_ff, row_in;
   logic [AXES-1:0][COORD_W-1:0] offset_ff, offset_in;

   assign csr_chan.ready = 1'b1;

   // register write decode
   always_comb begin
      form_in   = form_ff;
      row_in    = row_ff;
      offset_in = offset_ff;
      if (csr_chan.valid) begin
         unique case (csr_chan.reg_index)
            REG_FORM:     form_in      = form_type'(csr_chan.wdata[1:0]);
            REG_ROW_X:    row_in[0]    = csr_chan.wdata[ROW_W-1:0];
            REG_ROW_Y:    row_in[1]    = csr_chan.wdata[ROW_W-1:0];
            REG_ROW_Z:    row_in[2]    = csr_chan.wdata[ROW_W-1:0];
            REG_OFFSET_X: offset_in[0] = csr_chan.wdata[COORD_W-1:0];
            REG_OFFSET_Y: offset_in[1] = csr_chan.wdata[COORD_W-1:0];
            REG_OFFSET_Z: offset_in[2] = csr_chan.wdata[COORD_W-1:0];
            default: ;
         endcase
      end
   end

   // register file, reset to the identity matrix
   always_ff @(posedge clock) begin
      if (reset) begin
         form_ff <= FORM_IDENTITY;
         for (int r = 0; r < AXES; r++) begin
            row_ff[r]    <= ROW_W'(unsigned'(COEFF_ONE)) << (COEFF_W * r);
            offset_ff[r] <= '0;
         end
      end else begin
         form_ff   <= form_in;
         row_ff    <= row_in;
         offset_ff <= offset_in;
      end
   end

   // effective transform: identity and translation use a unit diagonal,
   // scale keeps only the diagonal, identity drops the offsets
   always_comb begin
      for (int r = 0; r < AXES; r++) begin
         for (int c = 0; c < AXES; c++) begin
            unique case (form_ff)
               FORM_IDENTITY, FORM_TRANSLATE:
                  xform.coeff[r][c] = (r == c) ? COEFF_ONE : '0;
               FORM_SCALE:
                  xform.coeff[r][c] = (r == c) ? row_ff[r][c*COEFF_W +: COEFF_W] : '0;
               FORM_AFFINE:
                  xform.coeff[r][c] = row_ff[r][c*COEFF_W +: COEFF_W];
               default:
                  xform.coeff[r][c] = '0;
            endcase
         end
         xform.offset[r] = (form_ff == FORM_IDENTITY) ? '0 : offset_ff[r];
      end
   end

endmodule

FILE: design/apt3_mul.sv
// ----------------------------------------------------------------------------
// apt3_mul
// First pipeline stage: nine 32x21 signed products and the offset moved to
// Q.32 with the rounding half folded in.
// ----------------------------------------------------------------------------
module apt3_mul (
   input  logic                   clock,
   input  logic                   reset,
   apt3_req_if.sink               req_chan,
   input  apt3_pkg::xform_type    xform,
   output logic                   out_valid,
   input  logic                   out_ready,
   output apt3_pkg::mul_data_type out_data
);
   import apt3_pkg::*;

   logic                         valid_ff;
   logic                         load;
   mul_data_type                 data_ff, data_in;
   logic [AXES-1:0][COORD_W-1:0] point;

   assign point[0] = req_chan.point_x;
   assign point[1] = req_chan.point_y;
   assign point[2] = req_chan.point_z;

   // stage takes a transfer when empty or when it drains
   assign load           = !valid_ff || out_ready;
   assign req_chan.ready = load;

   // products and biased offsets
   always_comb begin
      for (int r = 0; r < AXES; r++) begin
         for (int c = 0; c < AXES; c++) begin
            data_in.prod[r][c] = prod_type'(coord_type'(point[c])) *
                                 prod_type'(coeff_type'(xform.coeff[r][c]));
         end
         data_in.bias[r] = acc_type'($signed({xform.offset[r], ROUND_HALF}));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (load && req_chan.valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

FILE: design/apt3_acc.sv
// ----------------------------------------------------------------------------
// apt3_acc
// Second and third pipeline stages: pairwise sums of the products and bias,
// then the final sum with the floor shift that completes the rounding.
// ----------------------------------------------------------------------------
module apt3_acc (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   output logic                     in_ready,
   input  apt3_pkg::mul_data_type   in_data,
   output logic                     out_valid,
   input  logic                     out_ready,
   output apt3_pkg::round_data_type out_data
);
   import apt3_pkg::*;

   logic           part_valid_ff, sum_valid_ff;
   logic           part_load, sum_load;
   part_data_type  part_ff, part_in;
   round_data_type sum_ff, sum_in;
   acc_type        total [AXES];

   assign sum_load  = !sum_valid_ff || out_ready;
   assign part_load = !part_valid_ff || sum_load;
   assign in_ready  = part_load;

   // pairwise sums
   always_comb begin
      for (int r = 0; r < AXES; r++) begin
         part_in.part_a[r] = acc_type'(prod_type'(in_data.prod[r][0])) +
                             acc_type'(prod_type'(in_data.prod[r][1]));
         part_in.part_b[r] = acc_type'(prod_type'(in_data.prod[r][2])) +
                             acc_type'(in_data.bias[r]);
      end
   end

   // final sum and floor to Q.16
   always_comb begin
      for (int r = 0; r < AXES; r++) begin
         total[r]         = acc_type'(part_ff.part_a[r]) + acc_type'(part_ff.part_b[r]);
         sum_in.value[r]  = round_type'(total[r] >>> FRAC_W);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         part_valid_ff <= 1'b0;
         sum_valid_ff  <= 1'b0;
      end else begin
         if (part_load) begin
            part_valid_ff <= in_valid;
         end
         if (sum_load) begin
            sum_valid_ff <= part_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (part_load && in_valid) begin
         part_ff <= part_in;
      end
      if (sum_load && part_valid_ff) begin
         sum_ff <= sum_in;
      end
   end

   assign out_valid = sum_valid_ff;
   assign out_data  = sum_ff;

endmodule

FILE: design/apt3_sat.sv
// ----------------------------------------------------------------------------
// apt3_sat
// Last pipeline stage: clamps each rounded coordinate to 32 bits, flags any
// clamping and holds the result in the response register.
// ----------------------------------------------------------------------------
module apt3_sat (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   output logic                     in_ready,
   input  apt3_pkg::round_data_type in_data,
   apt3_rsp_if.source               rsp_chan
);
   import apt3_pkg::*;

   localparam logic [COORD_W-1:0] SAT_HI = {1'b0, {(COORD_W-1){1'b1}}};
   localparam logic [COORD_W-1:0] SAT_LO = {1'b1, {(COORD_W-1){1'b0}}};

   logic                         valid_ff;
   logic                         load;
   logic [AXES-1:0][COORD_W-1:0] coord_ff, coord_in;
   logic                         sat_ff, sat_in;
   logic [AXES-1:0]              over;

   assign load     = !valid_ff || rsp_chan.ready;
   assign in_ready = load;

   // clamp: out of range when the bits above the 32-bit sign disagree
   always_comb begin
      for (int r = 0; r < AXES; r++) begin
         over[r] = !((&in_data.value[r][ROUND_W-1:COORD_W-1]) ||
                     !(|in_data.value[r][ROUND_W-1:COORD_W-1]));
         if (over[r]) begin
            coord_in[r] = in_data.value[r][ROUND_W-1] ? SAT_LO : SAT_HI;
         end else begin
            coord_in[r] = in_data.value[r][COORD_W-1:0];
         end
      end
      sat_in = |over;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (load && in_valid) begin
         coord_ff <= coord_in;
         sat_ff   <= sat_in;
      end
   end

   assign rsp_chan.valid     = valid_ff;
   assign rsp_chan.out_x     = coord_ff[0];
   assign rsp_chan.out_y     = coord_ff[1];
   assign rsp_chan.out_z     = coord_ff[2];
   assign rsp_chan.saturated = sat_ff;

endmodule
